FILE: src/gcl_pkg.sv
// gcl_pkg: shared types and constants for the gcd and lcm block
// no dependencies
`default_nettype none
package gcl_pkg;
   localparam int DATA_WIDTH_DEF = 64;
   localparam int FIELD_WIDTH    = 64;

   localparam logic OP_GCD = 1'b0;
   localparam logic OP_LCM = 1'b1;

   typedef struct packed {
      logic                          operation;
      logic signed [FIELD_WIDTH-1:0] a;
      logic signed [FIELD_WIDTH-1:0] b;
   } req_type;

   typedef struct packed {
      logic signed [FIELD_WIDTH-1:0] result;
      logic                          overflow;
   } rsp_type;
endpackage
`default_nettype wire

FILE: src/gcl_core.sv
// gcl_core: sequencer around one shared add/subtract unit doing euclid
// remainders, the exact quotient and a shift-add multiply; uses gcl_pkg
`default_nettype none
module gcl_core import gcl_pkg::*; #(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic                  op,
   input  wire logic [DATA_WIDTH-1:0] a,
   input  wire logic [DATA_WIDTH-1:0] b,
   output logic                       done,
   output logic [DATA_WIDTH-1:0]      res,
   output logic                       ovf
);
   localparam int W  = DATA_WIDTH;
   localparam int CW = $clog2(W);
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CHECK = 3'd1;
   localparam logic [2:0] S_DIV   = 3'd2;
   localparam logic [2:0] S_QDIV  = 3'd3;
   localparam logic [2:0] S_MUL   = 3'd4;
   localparam logic [2:0] S_DONE  = 3'd5;
   localparam logic [W-1:0] SIGN  = {1'b1, {(W-1){1'b0}}};

   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [W-1:0]  x_ff, x_in, y_ff, y_in, n_ff, n_in, rem_ff, rem_in;
   logic [W-1:0]  ma_ff, ma_in, mb_ff, mb_in, res_ff, res_in;
   logic          neg_ff, neg_in, op_ff, op_in, ovf_ff, ovf_in;

   logic [W-1:0]  ma, mb, lim, dvs;
   logic [W:0]    opa;
   logic [W-1:0]  opb;
   logic          sub;
   logic [W+1:0]  sum;
   logic          ge, last;

   assign ma = a[W-1] ? (~a + 1'b1) : a;
   assign mb = b[W-1] ? (~b + 1'b1) : b;
   assign dvs = (state_ff == S_QDIV) ? x_ff : y_ff;
   assign last = (cnt_ff == '0);

   // shared unit: subtract for a division step, add for a multiply step
   always_comb begin
      sub = (state_ff != S_MUL);
      if (sub) begin
         opa = {rem_ff, n_ff[W-1]};
         opb = dvs;
      end else begin
         opa = {1'b0, rem_ff};
         opb = n_ff[0] ? x_ff : '0;
      end
      sum = {1'b0, opa} + (sub ? ~{2'b0, opb} : {2'b0, opb}) + {{(W+1){1'b0}}, sub};
      ge  = !sum[W+1];
   end

   assign lim = neg_ff ? SIGN : (SIGN - 1'b1);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      n_in     = n_ff;
      rem_in   = rem_ff;
      ma_in    = ma_ff;
      mb_in    = mb_ff;
      neg_in   = neg_ff;
      op_in    = op_ff;
      res_in   = res_ff;
      ovf_in   = ovf_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               ma_in  = ma;
               mb_in  = mb;
               x_in   = ma;
               y_in   = mb;
               op_in  = op;
               neg_in = a[W-1] ^ b[W-1];
               res_in = '0;
               ovf_in = 1'b0;
               if (op == OP_LCM && (a == '0 || b == '0)) begin
                  state_in = S_DONE;
               end else begin
                  state_in = S_CHECK;
               end
            end
         end
         S_CHECK: begin
            rem_in = '0;
            cnt_in = CW'(W - 1);
            if (y_ff == '0) begin
               if (op_ff == OP_GCD) begin
                  res_in   = x_ff;
                  state_in = S_DONE;
               end else begin
                  // x holds the gcd, now divide |a| by it
                  n_in     = ma_ff;
                  state_in = S_QDIV;
               end
            end else begin
               n_in     = x_ff;
               state_in = S_DIV;
            end
         end
         S_DIV, S_QDIV: begin
            rem_in = ge ? sum[W-1:0] : opa[W-1:0];
            n_in   = {n_ff[W-2:0], ge};
            cnt_in = cnt_ff - 1'b1;
            if (last) begin
               if (state_ff == S_DIV) begin
                  x_in     = y_ff;
                  y_in     = rem_in;
                  state_in = S_CHECK;
               end else begin
                  x_in     = n_in;
                  rem_in   = '0;
                  n_in     = mb_ff;
                  cnt_in   = CW'(W - 1);
                  state_in = S_MUL;
               end
            end
         end
         S_MUL: begin
            rem_in = sum[W:1];
            n_in   = {sum[0], n_ff[W-1:1]};
            cnt_in = cnt_ff - 1'b1;
            if (last) begin
               res_in   = neg_ff ? (~n_in + 1'b1) : n_in;
               ovf_in   = (rem_in != '0) || (n_in > lim);
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cnt_ff <= cnt_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      n_ff   <= n_in;
      rem_ff <= rem_in;
      ma_ff  <= ma_in;
      mb_ff  <= mb_in;
      neg_ff <= neg_in;
      op_ff  <= op_in;
      res_ff <= res_in;
      ovf_ff <= ovf_in;
   end

   assign done = (state_ff == S_DONE);
   assign res  = res_ff;
   assign ovf  = ovf_ff;
endmodule
`default_nettype wire

FILE: src/gcd_and_lcm.sv
// gcd_and_lcm: top level with valid/stall channels and result register
// uses gcl_pkg and gcl_core
`default_nettype none
// One item at a time. How long an item runs depends on its data and on the
// shared add/subtract unit in gcl_core: a gcd runs one division per
// euclid remainder; an lcm then adds the exact quotient and the shift-add
// multiply. An lcm with a zero operand goes straight to done with a zero
// result. req_stall stays high from acceptance until the result item is taken.
module gcd_and_lcm import gcl_pkg::*; #(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp
);
   logic                  busy_ff, busy_in, valid_ff, valid_in;
   rsp_type               rsp_ff, rsp_in;
   logic                  accept, done, ovf;
   logic [DATA_WIDTH-1:0] res;

   assign accept = req_valid && !req_stall;

   gcl_core #(.DATA_WIDTH(DATA_WIDTH)) u_core (
      .clock (clock),
      .reset (reset),
      .start (accept),
      .op    (req.operation),
      .a     (req.a[DATA_WIDTH-1:0]),
      .b     (req.b[DATA_WIDTH-1:0]),
      .done  (done),
      .res   (res),
      .ovf   (ovf)
   );

   always_comb begin
      busy_in  = busy_ff;
      valid_in = valid_ff;
      rsp_in   = rsp_ff;
      if (accept) begin
         busy_in = 1'b1;
      end
      if (done) begin
         valid_in        = 1'b1;
         rsp_in.result   = FIELD_WIDTH'(signed'(res));
         rsp_in.overflow = ovf;
      end else if (valid_ff && !rsp_stall) begin
         valid_in = 1'b0;
         busy_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign req_stall = busy_ff;
   assign rsp_valid = valid_ff;
   assign rsp       = rsp_ff;
endmodule
`default_nettype wire

FILE: src/gcl_checker.sv
// gcl_checker: port-level checks for gcd_and_lcm, bound to the top level
// uses gcl_pkg
`default_nettype none
module gcl_checker import gcl_pkg::*; (
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_stall,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp
);
   // one item in flight: accepting closes the input side
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input not stalled after accepting an item");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input open while a result item waits");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
      else $error("stalled result item changed");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("channels not idle after reset");
endmodule

bind gcd_and_lcm gcl_checker u_gcl_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp       (rsp)
);
`default_nettype wire
